// ===== hw/rtl/allen_cahn_stencil_stage_unit_macros.svh =====
// ----------------------------------------------------------------------------
// allen_cahn_stencil_stage_unit_macros.svh
// assertion macros shared by the stencil stage checker
// ----------------------------------------------------------------------------
`ifndef ALLEN_CAHN_STENCIL_STAGE_UNIT_MACROS_SVH
`define ALLEN_CAHN_STENCIL_STAGE_UNIT_MACROS_SVH

// clocked assertion, off while reset is low
`define ACSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ACSS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/acss_pkg.sv =====
// ----------------------------------------------------------------------------
// acss_pkg
// shared constants and types of the allen-cahn stencil stage
// ----------------------------------------------------------------------------
package acss_pkg;

    // register file
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REG_W      = 16;

    typedef enum logic [0:0] {
        CFG_STEP_SCALE = 1'b0,
        CFG_CUBIC_COEF = 1'b1
    } t_cfg_idx;

    localparam logic [REG_W-1:0] STEP_SCALE_RST = 16'd0;
    localparam logic [REG_W-1:0] CUBIC_COEF_RST = 16'd12943;

    // fixed-point formats of the two registers
    localparam int SCALE_FRAC = 16;
    localparam int COEF_FRAC  = 14;

    // product magnitudes are held at 2^PROD_LIMIT_LOG before their shift
    localparam int PROD_LIMIT_LOG = 62;

endpackage

// ===== hw/rtl/acss_cell_if.sv =====
// ----------------------------------------------------------------------------
// acss_cell_if
// input channel: one stencil cell with its neighbors and base value
// ----------------------------------------------------------------------------
interface acss_cell_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] center_value;
    logic signed [VALUE_WIDTH-1:0] north_value;
    logic signed [VALUE_WIDTH-1:0] south_value;
    logic signed [VALUE_WIDTH-1:0] east_value;
    logic signed [VALUE_WIDTH-1:0] west_value;
    logic signed [VALUE_WIDTH-1:0] base_value;

    modport source (
        output valid, center_value, north_value, south_value, east_value, west_value,
               base_value,
        input  ready
    );

    modport sink (
        input  valid, center_value, north_value, south_value, east_value, west_value,
               base_value,
        output ready
    );
endinterface

// ===== hw/rtl/acss_res_if.sv =====
// ----------------------------------------------------------------------------
// acss_res_if
// output channel: updated cell value and clip flag
// ----------------------------------------------------------------------------
interface acss_res_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] updated_value;
    logic                          saturated;

    modport source (
        output valid, updated_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, updated_value, saturated,
        output ready
    );
endinterface

// ===== hw/rtl/acss_mul_sat.sv =====
// ----------------------------------------------------------------------------
// acss_mul_sat
// registered signed multiply, magnitude clamp and flooring right shift
// ----------------------------------------------------------------------------
module acss_mul_sat #(
    parameter int A_W   = 16,
    parameter int B_W   = 16,
    parameter int SHIFT = 12,
    parameter int R_W   = 20
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    output logic signed [R_W-1:0] o_q
);
    localparam int P_W   = A_W + B_W;
    localparam int EXT_W = ((P_W > 64) ? P_W : 64) + 1;
    localparam int LIM_L = acss_pkg::PROD_LIMIT_LOG;

    logic signed [P_W-1:0]   prod;
    logic signed [EXT_W-1:0] prod_x;
    logic signed [EXT_W-1:0] lim;
    logic signed [EXT_W-1:0] clamped;
    logic signed [EXT_W-1:0] shifted;
    logic signed [R_W-1:0]   n_q;
    logic signed [R_W-1:0]   r_q;

    assign prod   = i_a * i_b;
    assign prod_x = {{(EXT_W-P_W){prod[P_W-1]}}, prod};
    assign lim    = {{(EXT_W-LIM_L-1){1'b0}}, 1'b1, {LIM_L{1'b0}}};

    always_comb begin
        if (prod_x > lim) begin
            clamped = lim;
        end else if (prod_x < -lim) begin
            clamped = -lim;
        end else begin
            clamped = prod_x;
        end
    end

    // arithmetic shift is a floor
    assign shifted = clamped >>> SHIFT;
    assign n_q     = shifted[R_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// ===== hw/rtl/allen_cahn_stencil_stage_unit.sv =====
// ----------------------------------------------------------------------------
// allen_cahn_stencil_stage_unit: pipelined stencil update from input transfer to registered result
// throughput 1 cell per cycle while the output is not stalled, through 4 multiply stages and the output register
// output stall freezes all stages together; no cell is lost or repeated
// reset (sync, active low) empties the pipeline and loads the register defaults
// ----------------------------------------------------------------------------
module allen_cahn_stencil_stage_unit #(
    parameter int VALUE_WIDTH = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    acss_cell_if.sink                         i_cell,
    acss_res_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [acss_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [acss_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [acss_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    localparam int W   = VALUE_WIDTH;
    localparam int RW  = acss_pkg::REG_W;
    localparam int CFW = acss_pkg::CFG_DATA_W;

    // widths of the intermediate terms, exact up to the product clamp
    localparam int SQ_P = ((2 * W) > 64) ? 64 : (2 * W);
    localparam int SQ_W = ((SQ_P - FRAC_BITS) > 2) ? (SQ_P - FRAC_BITS) : 2;
    localparam int CU_P = ((SQ_W + W) > 64) ? 64 : (SQ_W + W);
    localparam int CU_W = ((CU_P - FRAC_BITS) > 2) ? (CU_P - FRAC_BITS) : 2;
    localparam int PO_W = ((CU_W > W) ? CU_W : W) + 1;
    localparam int DA_P = ((PO_W + RW + 1) > 64) ? 64 : (PO_W + RW + 1);
    localparam int DA_W = ((DA_P - acss_pkg::COEF_FRAC) > 2) ?
                          (DA_P - acss_pkg::COEF_FRAC) : 2;
    localparam int LP_W = W + 3;
    localparam int RT_W = ((LP_W > DA_W) ? LP_W : DA_W) + 1;
    localparam int IN_P = ((RT_W + RW + 1) > 64) ? 64 : (RT_W + RW + 1);
    localparam int IN_W = ((IN_P - acss_pkg::SCALE_FRAC) > 2) ?
                          (IN_P - acss_pkg::SCALE_FRAC) : 2;
    localparam int SU_W = ((W > IN_W) ? W : IN_W) + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RW-1:0]        r_step_scale;
    logic [RW-1:0]        r_cubic_coef;
    logic                 cfg_wr;
    acss_pkg::t_cfg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // registers sit on 4-byte words, bit 2 picks the register
    assign cfg_idx = acss_pkg::t_cfg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_scale <= acss_pkg::STEP_SCALE_RST;
            r_cubic_coef <= acss_pkg::CUBIC_COEF_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                acss_pkg::CFG_STEP_SCALE: r_step_scale <= pwdata[RW-1:0];
                acss_pkg::CFG_CUBIC_COEF: r_cubic_coef <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            acss_pkg::CFG_STEP_SCALE: prdata = {{(CFW-RW){1'b0}}, r_step_scale};
            acss_pkg::CFG_CUBIC_COEF: prdata = {{(CFW-RW){1'b0}}, r_cubic_coef};
            default:                  prdata = '0;
        endcase
    end

    // registers are unsigned; give the multipliers a zero sign bit
    logic signed [RW:0] scale_s;
    logic signed [RW:0] coef_s;
    assign scale_s = {1'b0, r_step_scale};
    assign coef_s  = {1'b0, r_cubic_coef};

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together; the last stage is the
    // output register, so a new cell is taken whenever it is empty or drained
    // ------------------------------------------------------------------
    logic adv;
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;

    assign adv          = !r5_vld || o_res.ready;
    assign i_cell.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_cell.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: laplacian (adds only) and center squared
    // ------------------------------------------------------------------
    logic signed [LP_W-1:0] n_lap;
    logic signed [LP_W-1:0] r1_lap, r2_lap, r3_lap;
    logic signed [W-1:0]    r1_c, r2_c;
    logic signed [W-1:0]    r1_base, r2_base, r3_base, r4_base;

    always_comb begin
        n_lap = {{3{i_cell.north_value[W-1]}}, i_cell.north_value}
              + {{3{i_cell.south_value[W-1]}}, i_cell.south_value}
              + {{3{i_cell.east_value[W-1]}},  i_cell.east_value}
              + {{3{i_cell.west_value[W-1]}},  i_cell.west_value}
              - {i_cell.center_value[W-1], i_cell.center_value, 2'b00};
    end

    logic signed [SQ_W-1:0] sq;

    acss_mul_sat #(
        .A_W   (W),
        .B_W   (W),
        .SHIFT (FRAC_BITS),
        .R_W   (SQ_W)
    ) u_mul_sq (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (i_cell.center_value),
        .i_b   (i_cell.center_value),
        .o_q   (sq)
    );

    // side data rides along with the products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_lap  <= n_lap;
            r1_c    <= i_cell.center_value;
            r1_base <= i_cell.base_value;
            r2_lap  <= r1_lap;
            r2_c    <= r1_c;
            r2_base <= r1_base;
            r3_lap  <= r2_lap;
            r3_base <= r2_base;
            r4_base <= r3_base;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cube = floor(square * center)
    // ------------------------------------------------------------------
    logic signed [CU_W-1:0] cube;

    acss_mul_sat #(
        .A_W   (SQ_W),
        .B_W   (W),
        .SHIFT (FRAC_BITS),
        .R_W   (CU_W)
    ) u_mul_cube (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (sq),
        .i_b   (r1_c),
        .o_q   (cube)
    );

    // ------------------------------------------------------------------
    // stage 3: potential = cube - center, damped by the cubic coefficient
    // ------------------------------------------------------------------
    logic signed [PO_W-1:0] pot;
    logic signed [DA_W-1:0] damped;

    assign pot = {{(PO_W-CU_W){cube[CU_W-1]}}, cube}
               - {{(PO_W-W){r2_c[W-1]}}, r2_c};

    acss_mul_sat #(
        .A_W   (PO_W),
        .B_W   (RW + 1),
        .SHIFT (acss_pkg::COEF_FRAC),
        .R_W   (DA_W)
    ) u_mul_damp (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (pot),
        .i_b   (coef_s),
        .o_q   (damped)
    );

    // ------------------------------------------------------------------
    // stage 4: rate = laplacian - damped, scaled by the stage factor
    // ------------------------------------------------------------------
    logic signed [RT_W-1:0] rate;
    logic signed [IN_W-1:0] incr;

    assign rate = {{(RT_W-LP_W){r3_lap[LP_W-1]}}, r3_lap}
                - {{(RT_W-DA_W){damped[DA_W-1]}}, damped};

    acss_mul_sat #(
        .A_W   (RT_W),
        .B_W   (RW + 1),
        .SHIFT (acss_pkg::SCALE_FRAC),
        .R_W   (IN_W)
    ) u_mul_inc (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (rate),
        .i_b   (scale_s),
        .o_q   (incr)
    );

    // ------------------------------------------------------------------
    // stage 5: base + increment, clipped to the value range (output register)
    // ------------------------------------------------------------------
    logic signed [SU_W-1:0] sum;
    logic signed [SU_W-1:0] max_x;
    logic signed [SU_W-1:0] min_x;
    logic signed [W-1:0]    n_val;
    logic                   n_sat;
    logic signed [W-1:0]    r5_val;
    logic                   r5_sat;

    assign sum   = {{(SU_W-W){r4_base[W-1]}}, r4_base}
                 + {{(SU_W-IN_W){incr[IN_W-1]}}, incr};
    assign max_x = {{(SU_W-W+1){1'b0}}, {(W-1){1'b1}}};
    assign min_x = {{(SU_W-W+1){1'b1}}, {(W-1){1'b0}}};

    always_comb begin
        if (sum > max_x) begin
            n_val = max_x[W-1:0];
            n_sat = 1'b1;
        end else if (sum < min_x) begin
            n_val = min_x[W-1:0];
            n_sat = 1'b1;
        end else begin
            n_val = sum[W-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_val <= n_val;
            r5_sat <= n_sat;
        end
    end

    assign o_res.valid         = r5_vld;
    assign o_res.updated_value = r5_val;
    assign o_res.saturated     = r5_sat;
endmodule

// ===== hw/rtl/acss_checker.sv =====
// ----------------------------------------------------------------------------
// acss_checker
// port-level checks of the stencil stage, bound to the top level
// ----------------------------------------------------------------------------
`include "allen_cahn_stencil_stage_unit_macros.svh"

module acss_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [VALUE_WIDTH-1:0] i_updated_value,
    input logic                          i_saturated,
    input logic                          i_pready
);
    localparam logic [VALUE_WIDTH-1:0] MAX_V = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MIN_V = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // reset empties the pipeline
    `ACSS_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // stalled result holds
    `ACSS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_updated_value) && $stable(i_saturated), "stalled result changed")

    // an empty output stage always takes a cell
    `ACSS_ASSERT(a_in_ready, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // a clipped result sits on a range limit
    `ACSS_ASSERT(a_sat_limit, i_clk, i_rst_n, i_out_valid && i_saturated |-> (i_updated_value == MAX_V) || (i_updated_value == MIN_V), "clipped result off the limit")

    // register port never waits
    `ACSS_ASSERT(a_pready, i_clk, i_rst_n, i_pready && (i_in_valid || !i_in_valid), "pready dropped")
endmodule

bind allen_cahn_stencil_stage_unit acss_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_acss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cell.valid),
    .i_in_ready      (i_cell.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_updated_value (o_res.updated_value),
    .i_saturated     (o_res.saturated),
    .i_pready        (pready)
);
